FILE: rtl/ezq_pkg.sv
// ----------------------------------------------------------------------------
// ezq_pkg: shared types and constants for the euler zyx to quaternion block
// Half angle, cordic vector and arctangent table definitions used by the
// fold stage, the cordic cells, the product mixer and the top level.
// ----------------------------------------------------------------------------
package ezq_pkg;

  // cordic step count and lane assignment
  localparam int CORDIC_STEPS = 16;
  localparam int LANES        = 3;
  localparam int LANE_ROLL    = 0;
  localparam int LANE_PITCH   = 1;
  localparam int LANE_YAW     = 2;

  // half angle in units of 2^-16 rad, cos/sin in q.16
  localparam int ANG_W = 18;
  localparam int CS_W  = 18;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [CS_W-1:0]  cs_t;

  localparam logic signed [ANG_W:0] ANG_PI      = 19'sd205887;
  localparam ang_t                  ANG_HALF_PI = 18'sd102944;
  localparam cs_t                   CORDIC_START = 18'sd39797;

  // arctangent of 2^-i in units of 2^-16 rad
  localparam ang_t ATAN_TABLE [CORDIC_STEPS] = '{
    18'sd51472, 18'sd30386, 18'sd16055, 18'sd8150,
    18'sd4091,  18'sd2047,  18'sd1024,  18'sd512,
    18'sd256,   18'sd128,   18'sd64,    18'sd32,
    18'sd16,    18'sd8,     18'sd4,     18'sd2
  };

  // one rotating vector with its residual angle
  typedef struct packed {
    ang_t z;
    cs_t  y;
    cs_t  x;
  } lane_t;

  // the three angle lanes travelling together down the cordic chain
  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic  [LANES-1:0] flip;
  } cordic_bus_t;

endpackage

FILE: rtl/ezq_angle_fold.sv
// ----------------------------------------------------------------------------
// ezq_angle_fold: half angle and range fold
// Forms the half angle of each input, folds it into plus or minus pi/2 and
// loads the starting cordic vector for the chain.
// ----------------------------------------------------------------------------
module ezq_angle_fold import ezq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output cordic_bus_t        out_data
);

  logic signed [15:0]  ang [LANES];
  ang_t                half_ang [LANES];
  logic signed [ANG_W:0] wide_ang [LANES];
  logic signed [ANG_W:0] folded [LANES];
  cordic_bus_t         data_next;

  assign ang[LANE_ROLL]  = roll_angle;
  assign ang[LANE_PITCH] = pitch_angle;
  assign ang[LANE_YAW]   = yaw_angle;

  // half angle is the q2.13 input times four, then fold by pi
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      half_ang[l] = $signed({ang[l], 2'b00});
      wide_ang[l] = {half_ang[l][ANG_W-1], half_ang[l]};
      if (half_ang[l] > ANG_HALF_PI) begin
        folded[l]         = wide_ang[l] - ANG_PI;
        data_next.flip[l] = 1'b1;
      end else if (half_ang[l] < -ANG_HALF_PI) begin
        folded[l]         = wide_ang[l] + ANG_PI;
        data_next.flip[l] = 1'b1;
      end else begin
        folded[l]         = wide_ang[l];
        data_next.flip[l] = 1'b0;
      end
      data_next.lane[l].x = CORDIC_START;
      data_next.lane[l].y = '0;
      data_next.lane[l].z = folded[l][ANG_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/ezq_cordic_cell.sv
// ----------------------------------------------------------------------------
// ezq_cordic_cell: one rotation step of the cordic chain
// Rotates the three angle lanes by plus or minus atan(2^-STEP) and hands
// the vectors to the next cell.
// ----------------------------------------------------------------------------
module ezq_cordic_cell import ezq_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cordic_bus_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cordic_bus_t out_data
);

  localparam ang_t STEP_ATAN = ATAN_TABLE[STEP];

  cs_t         dx [LANES];
  cs_t         dy [LANES];
  cordic_bus_t data_next;

  // rotate toward zero residual angle
  always_comb begin
    data_next.flip = in_data.flip;
    for (int l = 0; l < LANES; l++) begin
      dx[l] = $signed(in_data.lane[l].y) >>> STEP;
      dy[l] = $signed(in_data.lane[l].x) >>> STEP;
      if (!in_data.lane[l].z[ANG_W-1]) begin
        data_next.lane[l].x = in_data.lane[l].x - dx[l];
        data_next.lane[l].y = in_data.lane[l].y + dy[l];
        data_next.lane[l].z = in_data.lane[l].z - STEP_ATAN;
      end else begin
        data_next.lane[l].x = in_data.lane[l].x + dx[l];
        data_next.lane[l].y = in_data.lane[l].y - dy[l];
        data_next.lane[l].z = in_data.lane[l].z + STEP_ATAN;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/ezq_quat_mix.sv
// ----------------------------------------------------------------------------
// ezq_quat_mix: triple products, sums and output rounding
// Six stage pipeline: sign fix, pair products, split partial products,
// triple product assembly, component sums, round and saturate to q1.14.
// ----------------------------------------------------------------------------
module ezq_quat_mix import ezq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cordic_bus_t        in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w
);

  localparam int STAGES = 6;
  localparam int PAIR_W = 2 * CS_W;
  localparam int TRIP_W = PAIR_W + CS_W;
  localparam int SUM_W  = TRIP_W + 1;
  localparam int RND_W  = SUM_W - 34;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'sd8589934592);
  localparam logic signed [RND_W-1:0] Q14_ONE    = RND_W'(16384);

  logic [STAGES-1:0] stage_valid;
  logic [STAGES:0]   adv;

  cs_t                     cos_q [LANES];
  cs_t                     sin_q [LANES];
  logic signed [PAIR_W-1:0] pr_cc, pr_ss, pr_sc, pr_cs;
  cs_t                     cy_q, sy_q;
  logic signed [PAIR_W-1:0] pair_op [8];
  cs_t                     ang_op [8];
  logic signed [PAIR_W-1:0] hi_part [8];
  logic signed [PAIR_W:0]   lo_part [8];
  logic signed [TRIP_W-1:0] triple [8];
  logic signed [SUM_W-1:0]  comp_sum [4];
  logic signed [SUM_W-1:0]  biased [4];
  logic signed [RND_W-1:0]  rnd [4];
  logic signed [15:0]       sat [4];
  logic signed [15:0]       quat_q [4];

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !stage_valid[k] || adv[k+1];
    end
  end
  assign in_ready  = adv[0];
  assign out_valid = stage_valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // operand select for the eight triple products
  always_comb begin
    pair_op[0] = pr_sc; ang_op[0] = cy_q;
    pair_op[1] = pr_cs; ang_op[1] = sy_q;
    pair_op[2] = pr_cs; ang_op[2] = cy_q;
    pair_op[3] = pr_sc; ang_op[3] = sy_q;
    pair_op[4] = pr_cc; ang_op[4] = sy_q;
    pair_op[5] = pr_ss; ang_op[5] = cy_q;
    pair_op[6] = pr_cc; ang_op[6] = cy_q;
    pair_op[7] = pr_ss; ang_op[7] = sy_q;
  end

  // round half up and saturate to plus or minus one
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      biased[c] = comp_sum[c] + ROUND_BIAS;
      rnd[c]    = biased[c][SUM_W-1:34];
      if (rnd[c] > Q14_ONE) begin
        sat[c] = 16'sd16384;
      end else if (rnd[c] < -Q14_ONE) begin
        sat[c] = -16'sd16384;
      end else begin
        sat[c] = rnd[c][15:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // undo the range fold
    if (adv[0]) begin
      for (int l = 0; l < LANES; l++) begin
        cos_q[l] <= in_data.flip[l] ? -in_data.lane[l].x : in_data.lane[l].x;
        sin_q[l] <= in_data.flip[l] ? -in_data.lane[l].y : in_data.lane[l].y;
      end
    end
    // roll by pitch pair products
    if (adv[1]) begin
      pr_cc <= cos_q[LANE_ROLL] * cos_q[LANE_PITCH];
      pr_ss <= sin_q[LANE_ROLL] * sin_q[LANE_PITCH];
      pr_sc <= sin_q[LANE_ROLL] * cos_q[LANE_PITCH];
      pr_cs <= cos_q[LANE_ROLL] * sin_q[LANE_PITCH];
      cy_q  <= cos_q[LANE_YAW];
      sy_q  <= sin_q[LANE_YAW];
    end
    // yaw term split into high signed and low unsigned partial products
    if (adv[2]) begin
      for (int t = 0; t < 8; t++) begin
        hi_part[t] <= $signed(pair_op[t][PAIR_W-1:CS_W]) * ang_op[t];
        lo_part[t] <= $signed({1'b0, pair_op[t][CS_W-1:0]}) * ang_op[t];
      end
    end
    // assemble exact triple products
    if (adv[3]) begin
      for (int t = 0; t < 8; t++) begin
        triple[t] <= {hi_part[t], {CS_W{1'b0}}}
                   + {{(TRIP_W-PAIR_W-1){lo_part[t][PAIR_W]}}, lo_part[t]};
      end
    end
    // component sums
    if (adv[4]) begin
      comp_sum[0] <= SUM_W'(triple[0]) - SUM_W'(triple[1]);
      comp_sum[1] <= SUM_W'(triple[2]) + SUM_W'(triple[3]);
      comp_sum[2] <= SUM_W'(triple[4]) - SUM_W'(triple[5]);
      comp_sum[3] <= SUM_W'(triple[6]) + SUM_W'(triple[7]);
    end
    // output register
    if (adv[5]) begin
      for (int c = 0; c < 4; c++) begin
        quat_q[c] <= sat[c];
      end
    end
  end

  assign quat_x = quat_q[0];
  assign quat_y = quat_q[1];
  assign quat_z = quat_q[2];
  assign quat_w = quat_q[3];

endmodule

FILE: rtl/euler_zyx_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion: zyx euler angles to unit quaternion
// Half angle fold, a chain of sixteen cordic cells for the cosine and sine of
// all three half angles, then a product pipeline to q1.14 components.
//
//   channel  signals                                    width
//   in       in_valid in_ready roll/pitch/yaw_angle     3 x 16 signed q2.13
//   out      out_valid out_ready quat_x/y/z/w           4 x 16 signed q1.14
//
// one item per cycle sustained while out_ready is high; the stages are the fold,
// 16 cordic cells and 6 product stages, each a register with its own valid bit.
// every stage moves when empty or when its successor moves, so bubbles
// close up while the output is stalled; in_ready drops only when all full.
// synchronous reset clears the valid bits only; no state between items.
// ----------------------------------------------------------------------------
module euler_zyx_to_quaternion import ezq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w
);

  cordic_bus_t            cell_data  [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  cell_valid;
  logic [CORDIC_STEPS:0]  cell_ready;

  // half angles and fold
  ezq_angle_fold u_fold (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .out_valid   (cell_valid[0]),
    .out_ready   (cell_ready[0]),
    .out_data    (cell_data[0])
  );

  // cordic chain
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
    ezq_cordic_cell #(
      .STEP (s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[s]),
      .in_ready  (cell_ready[s]),
      .in_data   (cell_data[s]),
      .out_valid (cell_valid[s+1]),
      .out_ready (cell_ready[s+1]),
      .out_data  (cell_data[s+1])
    );
  end

  // products, sums and rounding
  ezq_quat_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[CORDIC_STEPS]),
    .in_ready  (cell_ready[CORDIC_STEPS]),
    .in_data   (cell_data[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w)
  );

`ifndef NO_ASSERTIONS
  // backpressure reaches the input only when the whole chain is full
  a_full_chain: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&cell_valid) && out_valid && !out_ready)
    else $error("in_ready low with a free stage in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && (cell_valid == '0))
    else $error("valid item left after reset");

  // saturation keeps every component within plus or minus one; x and w are checked here
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_x <= 16'sd16384 && quat_x >= -16'sd16384
               && quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
    else $error("quaternion component beyond one");
`endif

endmodule

FILE: test/ezq_checker.sv
// ----------------------------------------------------------------------------
// ezq_checker: quaternion predictor and result checker
// Watches both channels of the euler zyx to quaternion block, predicts each
// quaternion from the accepted angles with a bit-exact cordic and product
// model, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ezq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  // half angle units are 2^-16 rad
  localparam int HALF_TURN   = 205887;
  localparam int QUARTER     = 102944;
  localparam int ROT_STEPS   = 16;
  localparam int ROT_START   = 39797;
  localparam longint Q14_MAX = 16384;

  localparam int ATAN_UNITS [ROT_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  quat_t quat_expected [$];

  // cosine and sine of half the angle, q.16, folded into cordic range
  function automatic void half_angle_rotate(input logic signed [15:0] ang,
                                            output longint c, output longint s);
    int  z;
    int  x;
    int  y;
    int  dx;
    int  dy;
    int  i;
    bit  flip;
    z = int'(ang) * 4;
    x = ROT_START;
    y = 0;
    flip = 1'b0;
    if (z > QUARTER) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_UNITS[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_UNITS[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  // q.48 sum to q1.14, round half up, clamp to plus or minus one
  function automatic logic signed [15:0] round_q14(input longint sum);
    longint r;
    r = (sum + (longint'(1) << 33)) >>> 34;
    if (r > Q14_MAX) r = Q14_MAX;
    if (r < -Q14_MAX) r = -Q14_MAX;
    return r[15:0];
  endfunction

  function automatic quat_t quat_from_angles(input logic signed [15:0] roll,
                                             input logic signed [15:0] pitch,
                                             input logic signed [15:0] yaw);
    longint rc, rs, pc, ps, yc, ys;
    quat_t  q;
    half_angle_rotate(roll, rc, rs);
    half_angle_rotate(pitch, pc, ps);
    half_angle_rotate(yaw, yc, ys);
    q.x = round_q14(rs * pc * yc - rc * ps * ys);
    q.y = round_q14(rc * ps * yc + rs * pc * ys);
    q.z = round_q14(rc * pc * ys - rs * ps * yc);
    q.w = round_q14(rc * pc * yc + rs * ps * ys);
    return q;
  endfunction

  // predict on accepted angles, compare on accepted quaternions
  always @(posedge clk) begin
    quat_t q;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
      quat_expected.delete();
    end else begin
      if (in_valid && in_ready)
        quat_expected.push_back(quat_from_angles(roll_angle, pitch_angle, yaw_angle));
      if (out_valid && out_ready) begin
        if (quat_expected.size() == 0) begin
          $error("quaternion item with no prediction waiting: x=%0d y=%0d z=%0d w=%0d",
                 quat_x, quat_y, quat_z, quat_w);
          fail_count <= fail_count + 1;
        end else begin
          q = quat_expected.pop_front();
          checked <= checked + 1;
          if (q.x !== quat_x || q.y !== quat_y || q.z !== quat_z || q.w !== quat_w)
            fail_count <= fail_count + 1;
          if (q.x !== quat_x)
            $error("quat_x mismatch: expected %0d, actual %0d", q.x, quat_x);
          if (q.y !== quat_y)
            $error("quat_y mismatch: expected %0d, actual %0d", q.y, quat_y);
          if (q.z !== quat_z)
            $error("quat_z mismatch: expected %0d, actual %0d", q.z, quat_z);
          if (q.w !== quat_w)
            $error("quat_w mismatch: expected %0d, actual %0d", q.w, quat_w);
        end
      end
      pending <= quat_expected.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for euler_zyx_to_quaternion
// Drives directed and random roll, pitch and yaw items with random idling on
// both channels, a long output hold-off and a drain pause; the checker module
// predicts and compares every quaternion, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int directed;
  int cycles;
  bit in_taken;
  bit tx_idle;
  bit rx_idle;
  bit hold_req;

  euler_zyx_to_quaternion dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .quat_w      (quat_w)
  );

  ezq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .quat_w      (quat_w),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // input handshake as seen just before each rising edge
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d quaternions outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item, with an optional idle burst first; returns after acceptance
  task automatic send_item(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                           input logic signed [15:0] yaw);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid    = 1'b1;
    roll_angle  = roll;
    pitch_angle = pitch;
    yaw_angle   = yaw;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    sent++;
  endtask

  // random angle: full range, near the fold boundary, small, or extreme
  function automatic logic signed [15:0] rand_angle();
    int a;
    case ($urandom_range(0, 4))
      0, 1: a = $urandom_range(0, 65535) - 32768;
      2:    a = ($urandom_range(0, 1) ? 25736 : -25736) + $urandom_range(0, 8) - 4;
      3:    a = $urandom_range(0, 4096) - 2048;
      default: a = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                         : -32768 + $urandom_range(0, 3);
    endcase
    return a[15:0];
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(rand_angle(), rand_angle(), rand_angle());
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    roll_angle  = '0;
    pitch_angle = '0;
    yaw_angle   = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    sent        = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // extremes, fold boundaries, quarter turns and the zero attitude
    send_item(16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd32767, 16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768, -16'sd32768);
    send_item(16'sd32767, 16'sd0, 16'sd0);
    send_item(16'sd0, -16'sd32768, 16'sd0);
    send_item(16'sd0, 16'sd0, 16'sd32767);
    send_item(-16'sd1, 16'sd1, -16'sd1);
    send_item(16'sd25736, 16'sd25737, -16'sd25736);
    send_item(-16'sd25737, 16'sd25736, 16'sd25737);
    send_item(16'sd12868, -16'sd12868, 16'sd12868);
    send_item(16'sd12868, 16'sd12868, 16'sd12868);
    send_item(-16'sd12868, -16'sd12868, -16'sd12868);
    send_item(16'sd8192, -16'sd8192, 16'sd4096);
    send_item(-16'sd32768, 16'sd32767, 16'sd0);
    send_item(16'sd0, 16'sd32767, -16'sd32768);
    send_item(16'sd25736, -16'sd25736, 16'sd0);
    send_item(16'sd6434, 16'sd12868, -16'sd25737);
    send_item(16'sd21845, -16'sd21846, 16'sd21845);
    directed = sent;

    send_random(500);

    // long output hold-off while items keep coming, so the pipe backs up
    hold_req = 1'b1;
    tx_idle  = 1'b0;
    send_random(120);
    tx_idle = 1'b1;

    // pause the sender until every quaternion is out
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);

    send_random(550);

    // last stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(420);
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d angle items (%0d directed) and %0d quaternions compared,",
             sent, directed, checked);
    $display("with random idling, a %0d-cycle output hold-off and a drain pause",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ezq_pkg.sv
rtl/ezq_angle_fold.sv
rtl/ezq_cordic_cell.sv
rtl/ezq_quat_mix.sv
rtl/euler_zyx_to_quaternion.sv
test/ezq_checker.sv
test/tb_top.sv
